>>> hw/rtl/fwcp_pkg.sv
package fwcp_pkg;

	localparam int unsigned ADDR_W   = 24;
	localparam int unsigned SIZE_W   = 25;
	localparam int unsigned COUNT_W  = 17;
	localparam int unsigned OPCODE_W = 8;
	localparam int unsigned KIND_W   = 3;

	// page size in bytes, a power of two
	localparam int unsigned PAGE_BYTES = 256;
	localparam int unsigned PAGE_W     = $clog2(PAGE_BYTES);

	localparam int unsigned S_DATA_W = 56;
	localparam int unsigned M_DATA_W = 80;

	// flash erase, program and write-disable instruction bytes
	localparam logic [OPCODE_W-1:0] OP_NONE      = 8'h00;
	localparam logic [OPCODE_W-1:0] OP_ERASE_64K = 8'hD8;
	localparam logic [OPCODE_W-1:0] OP_ERASE_32K = 8'h52;
	localparam logic [OPCODE_W-1:0] OP_ERASE_4K  = 8'h20;
	localparam logic [OPCODE_W-1:0] OP_PROGRAM   = 8'h02;
	localparam logic [OPCODE_W-1:0] OP_WRDI      = 8'h04;

	localparam logic [SIZE_W-1:0] BLK_64K  = 25'h0010000;
	localparam logic [SIZE_W-1:0] BLK_32K  = 25'h0008000;
	localparam logic [SIZE_W-1:0] BLK_4K   = 25'h0001000;
	localparam logic [SIZE_W-1:0] SECT_MSK = 25'h0000FFF;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDLE     = 3'd0,
		KIND_ERASE    = 3'd1,
		KIND_PROGRAM  = 3'd2,
		KIND_DISABLE  = 3'd3,
		KIND_REJECTED = 3'd4
	} kind_t;

	typedef enum logic {
		OPER_START = 1'b0,
		OPER_FETCH = 1'b1
	} oper_t;

endpackage

>>> hw/rtl/flash_write_command_planner.sv
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tdata, s_tuser (operation)
// m        out        m_tvalid/m_tready  m_tdata, m_tuser (command_kind), m_tlast
//
// one word per cycle while m does not stall: an input register feeds one pass of
// adds and compares on the cursor registers, and the command lands in the output register.
// a start that fits gives no output word; every other word gives exactly one.
// arst_n clears the planner to idle with empty input and output registers.
// a stall on m holds the output word, and the input register takes a new word
// only when the one it holds can move on.
module flash_write_command_planner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// start_address [23:0], request_size [48:24], zero pad
	input  logic [fwcp_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// opcode [7:0], flash_address [31:8], byte_count [48:32], source_offset [72:49], zero pad
	output logic [fwcp_pkg::M_DATA_W-1:0] m_tdata,
	// command_kind
	output logic [fwcp_pkg::KIND_W-1:0]   m_tuser,
	output logic                          m_tlast
);
	import fwcp_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ERASE,
		PH_PROGRAM,
		PH_DISABLE
	} phase_t;

	localparam logic [SIZE_W:0] FLASH_END = 26'd1 << ADDR_W;

	// input register
	logic              valid_s1;
	oper_t             oper_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SIZE_W-1:0] size_s1;

	// planner state
	phase_t            phase_q;
	logic [SIZE_W-1:0] erase_cursor_q;
	logic [SIZE_W-1:0] erase_limit_q;
	logic [SIZE_W-1:0] program_cursor_q;
	logic [SIZE_W-1:0] remaining_q;
	logic [ADDR_W-1:0] origin_q;

	// output register
	logic                out_valid_q;
	kind_t               kind_q;
	logic [OPCODE_W-1:0] opcode_q;
	logic [ADDR_W-1:0]   flash_addr_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ADDR_W-1:0]   offset_q;
	logic                last_q;

	logic advance;

	// combinational result of one word
	logic                emit;
	kind_t               kind_d;
	logic [OPCODE_W-1:0] opcode_d;
	logic [ADDR_W-1:0]   flash_addr_d;
	logic [COUNT_W-1:0]  count_d;
	logic [ADDR_W-1:0]   offset_d;
	logic                last_d;

	phase_t            phase_d;
	logic [SIZE_W-1:0] erase_cursor_d;
	logic [SIZE_W-1:0] erase_limit_d;
	logic [SIZE_W-1:0] program_cursor_d;
	logic [SIZE_W-1:0] remaining_d;
	logic [ADDR_W-1:0] origin_d;

	logic [SIZE_W:0]   end_sum;
	logic [SIZE_W:0]   limit_up;
	logic [SIZE_W-1:0] erase_left;
	logic [SIZE_W-1:0] erase_blk;
	logic [SIZE_W-1:0] erase_next;
	logic [PAGE_W:0]   page_room;
	logic [SIZE_W-1:0] chunk;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign end_sum  = {2'b00, addr_s1} + {1'b0, size_s1};
	assign limit_up = (end_sum + {1'b0, SECT_MSK}) & ~{1'b0, SECT_MSK};

	assign erase_left = erase_limit_q - erase_cursor_q;
	assign page_room  = (PAGE_W + 1)'(PAGE_BYTES) - {1'b0, program_cursor_q[PAGE_W-1:0]};
	assign chunk      = (remaining_q < SIZE_W'(page_room)) ? remaining_q : SIZE_W'(page_room);

	// greedy erase block: largest aligned block that still fits
	always_comb begin
		if (erase_cursor_q[15:0] == 16'd0 && erase_left >= BLK_64K) begin
			erase_blk = BLK_64K;
		end else if (erase_cursor_q[14:0] == 15'd0 && erase_left >= BLK_32K) begin
			erase_blk = BLK_32K;
		end else begin
			erase_blk = BLK_4K;
		end
	end
	assign erase_next = erase_cursor_q + erase_blk;

	always_comb begin
		emit             = 1'b1;
		kind_d           = KIND_IDLE;
		opcode_d         = OP_NONE;
		flash_addr_d     = '0;
		count_d          = '0;
		offset_d         = '0;
		last_d           = 1'b0;
		phase_d          = phase_q;
		erase_cursor_d   = erase_cursor_q;
		erase_limit_d    = erase_limit_q;
		program_cursor_d = program_cursor_q;
		remaining_d      = remaining_q;
		origin_d         = origin_q;
		if (oper_s1 == OPER_START) begin
			phase_d          = PH_IDLE;
			erase_cursor_d   = '0;
			erase_limit_d    = '0;
			program_cursor_d = '0;
			remaining_d      = '0;
			origin_d         = '0;
			if (end_sum > FLASH_END) begin
				kind_d = KIND_REJECTED;
				last_d = 1'b1;
			end else begin
				emit             = 1'b0;
				origin_d         = addr_s1;
				program_cursor_d = {1'b0, addr_s1};
				remaining_d      = size_s1;
				if (size_s1 == '0) begin
					phase_d = PH_DISABLE;
				end else begin
					erase_cursor_d = {1'b0, addr_s1} & ~SECT_MSK;
					erase_limit_d  = limit_up[SIZE_W-1:0];
					phase_d        = PH_ERASE;
				end
			end
		end else begin
			unique case (phase_q)
				PH_ERASE: begin
					kind_d         = KIND_ERASE;
					flash_addr_d   = erase_cursor_q[ADDR_W-1:0];
					count_d        = erase_blk[COUNT_W-1:0];
					erase_cursor_d = erase_next;
					if (erase_blk == BLK_64K) begin
						opcode_d = OP_ERASE_64K;
					end else if (erase_blk == BLK_32K) begin
						opcode_d = OP_ERASE_32K;
					end else begin
						opcode_d = OP_ERASE_4K;
					end
					if (erase_next >= erase_limit_q) begin
						phase_d = PH_PROGRAM;
					end
				end
				PH_PROGRAM: begin
					kind_d           = KIND_PROGRAM;
					opcode_d         = OP_PROGRAM;
					flash_addr_d     = program_cursor_q[ADDR_W-1:0];
					count_d          = chunk[COUNT_W-1:0];
					offset_d         = program_cursor_q[ADDR_W-1:0] - origin_q;
					program_cursor_d = program_cursor_q + chunk;
					remaining_d      = remaining_q - chunk;
					if (remaining_q == chunk) begin
						phase_d = PH_DISABLE;
					end
				end
				PH_DISABLE: begin
					kind_d   = KIND_DISABLE;
					opcode_d = OP_WRDI;
					last_d   = 1'b1;
					phase_d  = PH_IDLE;
				end
				default: begin
					kind_d = KIND_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			oper_s1          <= OPER_START;
			addr_s1          <= '0;
			size_s1          <= '0;
			phase_q          <= PH_IDLE;
			erase_cursor_q   <= '0;
			erase_limit_q    <= '0;
			program_cursor_q <= '0;
			remaining_q      <= '0;
			origin_q         <= '0;
			out_valid_q      <= 1'b0;
			kind_q           <= KIND_IDLE;
			opcode_q         <= OP_NONE;
			flash_addr_q     <= '0;
			count_q          <= '0;
			offset_q         <= '0;
			last_q           <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
				oper_s1  <= oper_t'(s_tuser);
				addr_s1  <= s_tdata[ADDR_W-1:0];
				size_s1  <= s_tdata[ADDR_W +: SIZE_W];
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				phase_q          <= phase_d;
				erase_cursor_q   <= erase_cursor_d;
				erase_limit_q    <= erase_limit_d;
				program_cursor_q <= program_cursor_d;
				remaining_q      <= remaining_d;
				origin_q         <= origin_d;
			end

			if (advance && emit) begin
				out_valid_q  <= 1'b1;
				kind_q       <= kind_d;
				opcode_q     <= opcode_d;
				flash_addr_q <= flash_addr_d;
				count_q      <= count_d;
				offset_q     <= offset_d;
				last_q       <= last_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {
		(M_DATA_W - OPCODE_W - 2 * ADDR_W - COUNT_W)'(0),
		offset_q,
		count_q,
		flash_addr_q,
		opcode_q
	};

endmodule
